[rtl/ppe_pkg.sv]
// ppe_pkg: shared types and constants of the per-port ewma traffic estimator
// no dependencies; used by every rtl file of the block by scoped names
package ppe_pkg;

   localparam int PORT_W     = 5;
   localparam int LEN_W      = 16;
   localparam int TIME_W     = 32;
   localparam int VOL_W      = 48;
   localparam int PKT_W      = 32;
   localparam int CNT_W      = 32;
   localparam int IVL_W      = 16;
   localparam int SHIFT_W    = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // port index extended to the widest address any legal depth needs
   localparam int PORT_EXT_W = 9;

   localparam logic [IVL_W-1:0]     IVL_RESET   = 16'd5;
   localparam logic [SHIFT_W-1:0]   SHIFT_RESET = 4'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT    = 4'd1;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic [VOL_W-1:0]  vol;
      logic [PKT_W-1:0]  pkt;
      logic [TIME_W-1:0] last_time;
      logic [CNT_W-1:0]  count;
   } acc_entry_type;

   typedef struct packed {
      logic              valid;
      logic [PORT_W-1:0] port;
   } est_req_type;

   typedef struct packed {
      logic              valid;
      logic              fire;
      logic [PORT_W-1:0] port;
      logic [VOL_W-1:0]  vol;
      logic [PKT_W-1:0]  pkt;
      logic [TIME_W-1:0] last_time;
      logic [CNT_W-1:0]  count;
   } acc_out_type;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [VOL_W-1:0]  vol;
      logic [PKT_W-1:0]  pkt;
      logic [VOL_W-1:0]  prediction;
      logic [TIME_W-1:0] last_time;
      logic [CNT_W-1:0]  count;
   } report_type;

endpackage

[rtl/ppe_acc_stage.sv]
// ppe_acc_stage: per-port volume, packet, time and update count memory with
// read-modify-write and bypass; decides whether the port reports
// depends on ppe_pkg
module ppe_acc_stage #(
   parameter int NUM_PORTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [ppe_pkg::PORT_W-1:0]        in_port,
   input  logic [ppe_pkg::LEN_W-1:0]         in_len,
   input  logic [ppe_pkg::TIME_W-1:0]        in_time,
   input  logic [ppe_pkg::IVL_W-1:0]         interval,
   output logic                              s1_busy,
   output ppe_pkg::est_req_type              est_req,
   output ppe_pkg::acc_out_type              acc_out
);

   localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

   ppe_pkg::acc_entry_type            acc_mem_ff [NUM_PORTS];
   logic [NUM_PORTS-1:0]              entry_valid_ff;
   ppe_pkg::acc_entry_type            rd_data_ff;
   logic                              rd_valid_ff;

   logic                              s1_valid_ff;
   logic [ppe_pkg::PORT_W-1:0]        s1_port_ff;
   logic [ppe_pkg::LEN_W-1:0]         s1_len_ff;
   logic [ppe_pkg::TIME_W-1:0]        s1_time_ff;

   logic                              byp_valid_ff;
   logic [ppe_pkg::PORT_W-1:0]        byp_port_ff;
   ppe_pkg::acc_entry_type            byp_data_ff;

   ppe_pkg::acc_out_type              out_ff;
   ppe_pkg::acc_out_type              out_in;

   logic [ppe_pkg::PORT_EXT_W-1:0]    in_ext;
   logic [ppe_pkg::PORT_EXT_W-1:0]    s1_ext;
   logic [AW-1:0]                     in_addr;
   logic [AW-1:0]                     s1_addr;

   ppe_pkg::acc_entry_type            old_entry;
   ppe_pkg::acc_entry_type            new_entry;
   logic [ppe_pkg::VOL_W:0]           vol_sum;
   logic [ppe_pkg::VOL_W-1:0]         vol_new;
   logic [ppe_pkg::PKT_W-1:0]         pkt_new;
   logic [ppe_pkg::TIME_W-1:0]        elapsed;
   logic                              fire;

   assign in_ext  = {{(ppe_pkg::PORT_EXT_W-ppe_pkg::PORT_W){1'b0}}, in_port};
   assign s1_ext  = {{(ppe_pkg::PORT_EXT_W-ppe_pkg::PORT_W){1'b0}}, s1_port_ff};
   assign in_addr = in_ext[AW-1:0];
   assign s1_addr = s1_ext[AW-1:0];

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= acc_mem_ff[in_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= entry_valid_ff[in_addr];
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         acc_mem_ff[s1_addr] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (s1_valid_ff) begin
         entry_valid_ff[s1_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         byp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_port_ff     <= in_port;
      s1_len_ff      <= in_len;
      s1_time_ff     <= in_time;
      byp_port_ff    <= s1_port_ff;
      byp_data_ff    <= new_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.fire      <= out_in.fire;
      out_ff.port      <= out_in.port;
      out_ff.vol       <= out_in.vol;
      out_ff.pkt       <= out_in.pkt;
      out_ff.last_time <= out_in.last_time;
      out_ff.count     <= out_in.count;
   end

   // previous write to the same port is not yet in the read data
   always_comb begin
      if (byp_valid_ff && (byp_port_ff == s1_port_ff)) begin
         old_entry = byp_data_ff;
      end else if (rd_valid_ff) begin
         old_entry = rd_data_ff;
      end else begin
         old_entry = '0;
      end
   end

   always_comb begin
      vol_sum = {1'b0, old_entry.vol}
              + {{(ppe_pkg::VOL_W+1-ppe_pkg::LEN_W){1'b0}}, s1_len_ff};
      vol_new = vol_sum[ppe_pkg::VOL_W] ? {ppe_pkg::VOL_W{1'b1}}
                                        : vol_sum[ppe_pkg::VOL_W-1:0];
      pkt_new = (&old_entry.pkt) ? old_entry.pkt : old_entry.pkt + 1'b1;
      elapsed = s1_time_ff - old_entry.last_time;
      fire    = elapsed > {{(ppe_pkg::TIME_W-ppe_pkg::IVL_W){1'b0}}, interval};

      if (fire) begin
         new_entry.vol       = '0;
         new_entry.pkt       = '0;
         new_entry.last_time = s1_time_ff;
         new_entry.count     = old_entry.count + 1'b1;
      end else begin
         new_entry.vol       = vol_new;
         new_entry.pkt       = pkt_new;
         new_entry.last_time = old_entry.last_time;
         new_entry.count     = old_entry.count;
      end

      out_in.valid     = s1_valid_ff;
      out_in.fire      = fire;
      out_in.port      = s1_port_ff;
      out_in.vol       = vol_new;
      out_in.pkt       = pkt_new;
      out_in.last_time = old_entry.last_time;
      out_in.count     = old_entry.count;
   end

   assign s1_busy       = s1_valid_ff;
   assign est_req.valid = s1_valid_ff;
   assign est_req.port  = s1_port_ff;
   assign acc_out       = out_ff;

endmodule

[rtl/ppe_est_stage.sv]
// ppe_est_stage: per-port smoothed estimate memory with read-modify-write,
// bypass and the shift-based ewma update; builds the report beat
// depends on ppe_pkg
module ppe_est_stage #(
   parameter int NUM_PORTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ppe_pkg::est_req_type              est_req,
   input  ppe_pkg::acc_out_type              acc_in,
   input  logic [ppe_pkg::SHIFT_W-1:0]       shift,
   output logic                              push,
   output ppe_pkg::report_type               report
);

   localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

   logic [ppe_pkg::VOL_W-1:0]         est_mem_ff [NUM_PORTS];
   logic [NUM_PORTS-1:0]              entry_valid_ff;
   logic [ppe_pkg::VOL_W-1:0]         rd_data_ff;
   logic                              rd_valid_ff;

   logic                              byp_valid_ff;
   logic [ppe_pkg::PORT_W-1:0]        byp_port_ff;
   logic [ppe_pkg::VOL_W-1:0]         byp_data_ff;

   logic [ppe_pkg::PORT_EXT_W-1:0]    req_ext;
   logic [ppe_pkg::PORT_EXT_W-1:0]    cur_ext;
   logic [AW-1:0]                     req_addr;
   logic [AW-1:0]                     cur_addr;

   logic                              update;
   logic [ppe_pkg::VOL_W-1:0]         est_old;
   logic signed [ppe_pkg::VOL_W:0]    delta;
   logic signed [ppe_pkg::VOL_W:0]    delta_sh;
   logic signed [ppe_pkg::VOL_W:0]    est_sum;
   logic [ppe_pkg::VOL_W-1:0]         est_new;

   assign req_ext  = {{(ppe_pkg::PORT_EXT_W-ppe_pkg::PORT_W){1'b0}}, est_req.port};
   assign cur_ext  = {{(ppe_pkg::PORT_EXT_W-ppe_pkg::PORT_W){1'b0}}, acc_in.port};
   assign req_addr = req_ext[AW-1:0];
   assign cur_addr = cur_ext[AW-1:0];
   assign update   = acc_in.valid & acc_in.fire;

   always_ff @(posedge clock) begin
      if (est_req.valid) begin
         rd_data_ff <= est_mem_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         est_mem_ff[cur_addr] <= est_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff    <= 1'b0;
         byp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         rd_valid_ff  <= entry_valid_ff[req_addr];
         byp_valid_ff <= update;
         if (update) begin
            entry_valid_ff[cur_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_port_ff <= acc_in.port;
      byp_data_ff <= est_new;
   end

   // new = old + floor((vol - old) / 2^k)
   always_comb begin
      if (byp_valid_ff && (byp_port_ff == acc_in.port)) begin
         est_old = byp_data_ff;
      end else if (rd_valid_ff) begin
         est_old = rd_data_ff;
      end else begin
         est_old = '0;
      end
      delta    = $signed({1'b0, acc_in.vol}) - $signed({1'b0, est_old});
      delta_sh = delta >>> shift;
      est_sum  = $signed({1'b0, est_old}) + delta_sh;
      est_new  = est_sum[ppe_pkg::VOL_W-1:0];
   end

   assign push              = update;
   assign report.port       = acc_in.port;
   assign report.vol        = acc_in.vol;
   assign report.pkt        = acc_in.pkt;
   assign report.prediction = est_new;
   assign report.last_time  = acc_in.last_time;
   assign report.count      = acc_in.count;

endmodule

[rtl/ppe_rsp_fifo.sv]
// ppe_rsp_fifo: small result queue between the estimate stage and the
// response channel; depends on ppe_pkg
module ppe_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  ppe_pkg::report_type               push_data,
   input  logic                              pop_ready,
   output logic                              out_valid,
   output ppe_pkg::report_type               out_data,
   output logic [ppe_pkg::RSP_CNT_W-1:0]     count
);

   ppe_pkg::report_type                 queue_ff [ppe_pkg::RSP_DEPTH];
   logic [ppe_pkg::RSP_PTR_W-1:0]       wr_ptr_ff;
   logic [ppe_pkg::RSP_PTR_W-1:0]       wr_ptr_in;
   logic [ppe_pkg::RSP_PTR_W-1:0]       rd_ptr_ff;
   logic [ppe_pkg::RSP_PTR_W-1:0]       rd_ptr_in;
   logic [ppe_pkg::RSP_CNT_W-1:0]       count_ff;
   logic [ppe_pkg::RSP_CNT_W-1:0]       count_in;
   logic                                pop;

   assign pop = pop_ready & (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{(ppe_pkg::RSP_CNT_W-1){1'b0}}, push}
                           - {{(ppe_pkg::RSP_CNT_W-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = queue_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

[rtl/per_port_ewma_traffic_estimator.sv]
// Per-port EWMA traffic estimator. Takes one packet beat per clock cycle
// while req_ready is high and produces a report beat for a packet closing
// its port's interval, via the counter stage, its output register and the
// result queue. Per-port counters live in one memory and the smoothed
// estimates in a second, each with a registered read and a bypass register,
// so packets to one port may follow back to back. A four-entry result
// queue decouples the response channel; req_ready drops only when that
// queue and the two packets in flight could overflow it. Packets naming a
// port at or above NUM_PORTS are accepted and dropped. All per-port state
// is zero after reset with no clearing pass, through per-entry valid flags.
// depends on ppe_pkg, ppe_acc_stage, ppe_est_stage, ppe_rsp_fifo
module per_port_ewma_traffic_estimator #(
   parameter int NUM_PORTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ppe_pkg::PORT_W-1:0]        req_port_index,
   input  logic [ppe_pkg::LEN_W-1:0]         req_byte_length,
   input  logic [ppe_pkg::TIME_W-1:0]        req_time_seconds,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ppe_pkg::PORT_W-1:0]        rsp_report_port,
   output logic [ppe_pkg::VOL_W-1:0]         rsp_report_volume,
   output logic [ppe_pkg::PKT_W-1:0]         rsp_report_packets,
   output logic [ppe_pkg::VOL_W-1:0]         rsp_report_prediction,
   output logic [ppe_pkg::TIME_W-1:0]        rsp_report_last_time,
   output logic [ppe_pkg::CNT_W-1:0]         rsp_report_count,

   input  logic                              csr_write_enable,
   input  logic [ppe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppe_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [ppe_pkg::PORT_EXT_W-1:0] PORT_LIMIT = ppe_pkg::PORT_EXT_W'(NUM_PORTS);

   logic [ppe_pkg::IVL_W-1:0]         interval_ff;
   logic [ppe_pkg::SHIFT_W-1:0]       shift_ff;

   logic                              accept;
   logic                              in_range;
   logic                              s1_busy;
   ppe_pkg::est_req_type              est_req;
   ppe_pkg::acc_out_type              acc_out;
   logic                              push;
   ppe_pkg::report_type               push_data;
   ppe_pkg::report_type               rsp_data;
   logic [ppe_pkg::RSP_CNT_W-1:0]     fifo_count;
   logic [ppe_pkg::RSP_CNT_W-1:0]     pending;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= ppe_pkg::IVL_RESET;
         shift_ff    <= ppe_pkg::SHIFT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ppe_pkg::CSR_INTERVAL: begin
               interval_ff <= csr_wdata[ppe_pkg::IVL_W-1:0];
            end
            ppe_pkg::CSR_SHIFT: begin
               shift_ff <= csr_wdata[ppe_pkg::SHIFT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // reserve queue room for every beat that may still push a report
   assign pending   = fifo_count
                    + {{(ppe_pkg::RSP_CNT_W-1){1'b0}}, s1_busy}
                    + {{(ppe_pkg::RSP_CNT_W-1){1'b0}}, acc_out.valid};
   assign req_ready = pending < ppe_pkg::RSP_CNT_W'(ppe_pkg::RSP_DEPTH);
   assign accept    = req_valid & req_ready;
   assign in_range  = {{(ppe_pkg::PORT_EXT_W-ppe_pkg::PORT_W){1'b0}}, req_port_index}
                      < PORT_LIMIT;

   ppe_acc_stage #(
      .NUM_PORTS (NUM_PORTS)
   ) u_acc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept & in_range),
      .in_port  (req_port_index),
      .in_len   (req_byte_length),
      .in_time  (req_time_seconds),
      .interval (interval_ff),
      .s1_busy  (s1_busy),
      .est_req  (est_req),
      .acc_out  (acc_out)
   );

   ppe_est_stage #(
      .NUM_PORTS (NUM_PORTS)
   ) u_est (
      .clock   (clock),
      .reset   (reset),
      .est_req (est_req),
      .acc_in  (acc_out),
      .shift   (shift_ff),
      .push    (push),
      .report  (push_data)
   );

   ppe_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   assign rsp_report_port       = rsp_data.port;
   assign rsp_report_volume     = rsp_data.vol;
   assign rsp_report_packets    = rsp_data.pkt;
   assign rsp_report_prediction = rsp_data.prediction;
   assign rsp_report_last_time  = rsp_data.last_time;
   assign rsp_report_count      = rsp_data.count;

endmodule

[rtl/ppe_checker.sv]
// ppe_checker: port-level checks of the per-port ewma traffic estimator,
// bound to the top level; depends on ppe_pkg
module ppe_checker #(
   parameter int NUM_PORTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [ppe_pkg::PORT_W-1:0]        rsp_report_port,
   input  logic [ppe_pkg::VOL_W-1:0]         rsp_report_volume
);

   localparam logic [ppe_pkg::PORT_EXT_W-1:0] PORT_LIMIT = ppe_pkg::PORT_EXT_W'(NUM_PORTS);

   // a stalled report beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_report_port)
                                  && $stable(rsp_report_volume))
      else $error("report beat changed while stalled");

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report beat present after reset");

   // a report appearing on an empty channel comes from an accepted packet beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("report beat without matching packet beat");

   // only existing ports report
   a_port_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({{(ppe_pkg::PORT_EXT_W-ppe_pkg::PORT_W){1'b0}}, rsp_report_port}
                     < PORT_LIMIT))
      else $error("report for a port beyond the configured count");

endmodule

bind per_port_ewma_traffic_estimator ppe_checker #(
   .NUM_PORTS (NUM_PORTS)
) u_ppe_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_report_port   (rsp_report_port),
   .rsp_report_volume (rsp_report_volume)
);
